@@ sv/fcld_pkg.sv @@
package fcld_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int LEN_W      = LINE_AW + 1;
    localparam int CMD_MAX    = 8;
    localparam int CMD_AW     = 3;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REG_CMD_TEXT  = 2'd0;
    localparam logic [1:0] REG_CMD_LEN   = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_TIMEOUT   = 2'd3;

    typedef enum logic [1:0] {
        FIRE_NONE      = 2'd0,
        FIRE_DETECTED  = 2'd1,
        FIRE_CONFIRMED = 2'd2
    } fire_state_t;

    typedef struct packed {
        logic is_nul;
        logic is_blank;
        logic fold_eq;
    } char_class_t;

endpackage

@@ sv/fire_command_line_debouncer.sv @@
// Fire command line debouncer.
// Input stream: s_tdata carries a received serial byte, s_tuser tells a byte (0)
// from a one-millisecond tick (1). Every accepted word yields exactly one status
// word on the output stream (m_tdata), carrying the detector state, the
// suppression flag, per-word pulses and the wrapping fire event count.
// Ordinary bytes and ticks pass through the emit state before m_tvalid rises, and
// s_tready is high again from the edge that raises m_tvalid.
// A CR or LF that ends a non-empty line starts a walk over the line buffer, one
// byte per cycle through a RAM with separate write and read ports and a shared
// character compare unit. s_tready is low while a word is at work; one word is
// taken at a time.
// The result sits in an output register, so the next word is accepted while a
// result still waits; if m_tready stays low, the following result is held and
// s_tready drops until the output register frees.
// The APB port writes and reads the command text, command length, confirm
// threshold and timeout at byte addresses 0, 8, 16 and 24.
// Reset clears the line, detector state, counters and timer and restores the
// default configuration; the line RAM needs no clearing pass.
module fire_command_line_debouncer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fire_state[1:0], suppression_on, command_seen,
                                   // trigger_suppression, suppression_cleared,
                                   // event_total[15:0], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import fcld_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_EMIT
    } seq_state_t;

    logic [63:0] cmd_text_reg;
    logic [3:0]  cmd_len_reg;
    logic [7:0]  thr_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  reg_sel;

    seq_state_t          state_reg, state_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [23:0]         m_tdata_reg, m_tdata_next;
    logic [LEN_W-1:0]    line_len_reg, line_len_next;
    logic [LEN_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                data_vld_reg, data_vld_next;
    logic [LINE_AW-1:0]  data_idx_reg, data_idx_next;
    logic                nul_seen_reg, nul_seen_next;
    logic                found_reg, found_next;
    logic [LINE_AW-1:0]  start_reg, start_next;
    logic [LINE_AW-1:0]  last_reg, last_next;
    logic [CMD_MAX-1:0]  match_bits_reg, match_bits_next;
    fire_state_t         fire_reg, fire_next;
    logic [7:0]          count_reg, count_next;
    logic [15:0]         idle_reg, idle_next;
    logic                active_reg, active_next;
    logic [15:0]         events_reg, events_next;
    logic                seen_reg, seen_next;
    logic                trig_reg, trig_next;
    logic                cleared_reg, cleared_next;

    logic                accept;
    logic                is_eol;
    logic                wr_en;
    logic                rd_en;
    logic [7:0]          rd_data;
    logic [LINE_AW-1:0]  k_full;
    logic [CMD_AW-1:0]   k_low;
    logic                in_win;
    logic [7:0]          cmd_byte;
    char_class_t         cls;
    logic [LEN_W-1:0]    n_trim;
    logic [3:0]          cl;
    logic [CMD_MAX:0]    need_mask;
    logic                line_match;
    logic [7:0]          count_inc;
    logic [15:0]         idle_inc;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_text_reg <= 64'd0;
            cmd_len_reg  <= 4'd4;
            thr_reg      <= 8'd3;
            timeout_reg  <= 16'd3000;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_CMD_TEXT:  cmd_text_reg <= pwdata;
                REG_CMD_LEN:   cmd_len_reg  <= pwdata[3:0];
                REG_THRESHOLD: thr_reg      <= pwdata[7:0];
                REG_TIMEOUT:   timeout_reg  <= pwdata[15:0];
                default:       cmd_text_reg <= cmd_text_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CMD_TEXT:  prdata = cmd_text_reg;
            REG_CMD_LEN:   prdata = {60'd0, cmd_len_reg};
            REG_THRESHOLD: prdata = {56'd0, thr_reg};
            REG_TIMEOUT:   prdata = {48'd0, timeout_reg};
            default:       prdata = 64'd0;
        endcase
    end

    // line buffer and shared compare unit
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_eol   = (s_tdata == CH_LF) || (s_tdata == CH_CR);
    assign wr_en    = accept && (s_tuser == OP_BYTE) && !is_eol
                      && (int'(line_len_reg) < LINE_DEPTH - 1);
    assign rd_en    = (state_reg == S_SCAN) && (rd_idx_reg < line_len_reg);

    fcld_line_ram u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (line_len_reg[LINE_AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[LINE_AW-1:0]),
        .rd_data (rd_data)
    );

    assign k_full   = data_idx_reg - (found_reg ? start_reg : data_idx_reg);
    assign k_low    = CMD_AW'(k_full);
    assign in_win   = int'(k_full) < CMD_MAX;
    assign cmd_byte = 8'(cmd_text_reg >> {k_low, 3'b000});

    fcld_char_unit u_char_unit (
        .line_byte (rd_data),
        .cmd_byte  (cmd_byte),
        .cls       (cls)
    );

    // trimmed length and final verdict
    assign n_trim     = found_reg ? (LEN_W'(last_reg) - LEN_W'(start_reg) + LEN_W'(1))
                                  : LEN_W'(0);
    assign cl         = (cmd_len_reg > 4'd8) ? 4'd8 : cmd_len_reg;
    assign need_mask  = (CMD_MAX+1)'((CMD_MAX+1)'(1) << cl) - (CMD_MAX+1)'(1);
    assign line_match = (int'(n_trim) == int'(cl))
                        && (&(match_bits_reg | ~need_mask[CMD_MAX-1:0]));
    assign count_inc  = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
    assign idle_inc   = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        line_len_next   = line_len_reg;
        rd_idx_next     = rd_idx_reg;
        data_vld_next   = 1'b0;
        data_idx_next   = data_idx_reg;
        nul_seen_next   = nul_seen_reg;
        found_next      = found_reg;
        start_next      = start_reg;
        last_next       = last_reg;
        match_bits_next = match_bits_reg;
        fire_next       = fire_reg;
        count_next      = count_reg;
        idle_next       = idle_reg;
        active_next     = active_reg;
        events_next     = events_reg;
        seen_next       = seen_reg;
        trig_next       = trig_reg;
        cleared_next    = cleared_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    seen_next    = 1'b0;
                    trig_next    = 1'b0;
                    cleared_next = 1'b0;
                    state_next   = S_EMIT;
                    if (s_tuser == OP_TICK)
                    begin
                        idle_next = idle_inc;
                        if (fire_reg != FIRE_NONE && idle_inc > timeout_reg)
                        begin
                            cleared_next = active_reg;
                            fire_next    = FIRE_NONE;
                            count_next   = 8'd0;
                            active_next  = 1'b0;
                        end
                    end
                    else if (is_eol)
                    begin
                        if (line_len_reg != LEN_W'(0))
                        begin
                            rd_idx_next     = LEN_W'(0);
                            nul_seen_next   = 1'b0;
                            found_next      = 1'b0;
                            match_bits_next = '0;
                            state_next      = S_SCAN;
                        end
                    end
                    else if (wr_en)
                    begin
                        line_len_next = line_len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        // overflow: restart line, drop byte
                        line_len_next = LEN_W'(0);
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_en)
                begin
                    rd_idx_next   = rd_idx_reg + LEN_W'(1);
                    data_vld_next = 1'b1;
                    data_idx_next = rd_idx_reg[LINE_AW-1:0];
                end
                if (data_vld_reg && !nul_seen_reg)
                begin
                    if (cls.is_nul)
                    begin
                        nul_seen_next = 1'b1;
                    end
                    else if (!cls.is_blank)
                    begin
                        if (!found_reg)
                        begin
                            found_next = 1'b1;
                            start_next = data_idx_reg;
                        end
                        last_next = data_idx_reg;
                        if (in_win)
                        begin
                            match_bits_next[k_low] = cls.fold_eq;
                        end
                    end
                    else if (found_reg && in_win)
                    begin
                        match_bits_next[k_low] = cls.fold_eq;
                    end
                end
                if (!rd_en && !data_vld_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                line_len_next = LEN_W'(0);
                if (line_match)
                begin
                    seen_next  = 1'b1;
                    idle_next  = 16'd0;
                    count_next = count_inc;
                    if (fire_reg == FIRE_NONE)
                    begin
                        fire_next   = FIRE_DETECTED;
                        events_next = events_reg + 16'd1;
                    end
                    if (count_inc >= thr_reg
                        && (fire_reg == FIRE_NONE || fire_reg == FIRE_DETECTED))
                    begin
                        fire_next   = FIRE_CONFIRMED;
                        active_next = 1'b1;
                        trig_next   = 1'b1;
                    end
                    else
                    begin
                        trig_next = (fire_reg == FIRE_CONFIRMED);
                    end
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, events_reg, cleared_reg, trig_reg, seen_reg,
                                     active_reg, fire_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            line_len_reg   <= '0;
            rd_idx_reg     <= '0;
            data_vld_reg   <= 1'b0;
            nul_seen_reg   <= 1'b0;
            found_reg      <= 1'b0;
            fire_reg       <= FIRE_NONE;
            count_reg      <= 8'd0;
            idle_reg       <= 16'd0;
            active_reg     <= 1'b0;
            events_reg     <= 16'd0;
            seen_reg       <= 1'b0;
            trig_reg       <= 1'b0;
            cleared_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            line_len_reg   <= line_len_next;
            rd_idx_reg     <= rd_idx_next;
            data_vld_reg   <= data_vld_next;
            nul_seen_reg   <= nul_seen_next;
            found_reg      <= found_next;
            fire_reg       <= fire_next;
            count_reg      <= count_next;
            idle_reg       <= idle_next;
            active_reg     <= active_next;
            events_reg     <= events_next;
            seen_reg       <= seen_next;
            trig_reg       <= trig_next;
            cleared_reg    <= cleared_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg    <= m_tdata_next;
        data_idx_reg   <= data_idx_next;
        start_reg      <= start_next;
        last_reg       <= last_next;
        match_bits_reg <= match_bits_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/fcld_line_ram.sv @@
module fcld_line_ram (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [fcld_pkg::LINE_AW-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [fcld_pkg::LINE_AW-1:0] rd_addr,
    output logic [7:0]                   rd_data
);
    import fcld_pkg::*;

    logic [7:0] mem [LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/fcld_char_unit.sv @@
module fcld_char_unit (
    input  logic                  [7:0] line_byte,
    input  logic                  [7:0] cmd_byte,
    output fcld_pkg::char_class_t       cls
);
    import fcld_pkg::*;

    logic [7:0] line_fold;
    logic [7:0] cmd_fold;

    always_comb
    begin
        line_fold = line_byte;
        cmd_fold  = cmd_byte;
        if (line_byte >= 8'h41 && line_byte <= 8'h5A)
        begin
            line_fold = line_byte + 8'h20;
        end
        if (cmd_byte >= 8'h41 && cmd_byte <= 8'h5A)
        begin
            cmd_fold = cmd_byte + 8'h20;
        end
        cls.is_nul   = (line_byte == 8'h00);
        cls.is_blank = (line_byte == 8'h20) || (line_byte >= 8'h09 && line_byte <= 8'h0D);
        cls.fold_eq  = (line_fold == cmd_fold);
    end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

    import fcld_pkg::*;

    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] events;
        logic        cleared;
        logic        trig;
        logic        seen;
        logic        supp;
        fire_state_t state;
    } status_t;

    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // detector copy
    logic [7:0]       line_buf [LINE_DEPTH];
    logic [LEN_W-1:0] line_len;
    fire_state_t      det_state;
    logic [7:0]       match_cnt;
    logic [15:0]      idle_ms;
    logic             suppress_on;
    logic [15:0]      events_begun;
    logic [63:0]      cmd_text;
    logic [3:0]       cmd_len;
    logic [7:0]       threshold;
    logic [15:0]      timeout_ms;

    status_t pending_status [$];
    int      mismatches    = 0;
    int      words_sent    = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_left     = 0;

    fire_command_line_debouncer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    function automatic bit blank_char(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic bit line_matches_command();
        int lo;
        int hi;
        int n;
        int k;
        int want_len;
        lo = 0;
        hi = 0;
        while (hi < line_len && line_buf[hi] != 8'h00)
            hi++;
        while (lo < hi && blank_char(line_buf[lo]))
            lo++;
        while (hi > lo && blank_char(line_buf[hi - 1]))
            hi--;
        n = hi - lo;
        want_len = (cmd_len > CMD_MAX) ? CMD_MAX : cmd_len;
        if (n != want_len)
            return 1'b0;
        for (k = 0; k < n; k++)
            if (fold_case(line_buf[lo + k]) != fold_case(cmd_text[8 * k +: 8]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic status_t step_detector(logic op, logic [7:0] ch);
        status_t s;
        s = '0;
        if (op == OP_BYTE)
        begin
            if (ch == CH_LF || ch == CH_CR)
            begin
                if (line_len != 0)
                begin
                    if (line_matches_command())
                    begin
                        s.seen  = 1'b1;
                        idle_ms = '0;
                        if (match_cnt != 8'hFF)
                            match_cnt++;
                        if (det_state == FIRE_NONE)
                        begin
                            det_state = FIRE_DETECTED;
                            events_begun++;
                        end
                        if (match_cnt >= threshold && det_state == FIRE_DETECTED)
                        begin
                            det_state   = FIRE_CONFIRMED;
                            suppress_on = 1'b1;
                        end
                        s.trig = (det_state == FIRE_CONFIRMED);
                    end
                    line_len = '0;
                end
            end
            else if (line_len < LINE_DEPTH - 1)
            begin
                line_buf[line_len] = ch;
                line_len++;
            end
            else
            begin
                line_len = '0;
            end
        end
        else
        begin
            if (idle_ms != 16'hFFFF)
                idle_ms++;
            if (det_state != FIRE_NONE && idle_ms > timeout_ms)
            begin
                s.cleared   = suppress_on;
                det_state   = FIRE_NONE;
                match_cnt   = '0;
                suppress_on = 1'b0;
            end
        end
        s.state  = det_state;
        s.supp   = suppress_on;
        s.events = events_begun;
        return s;
    endfunction

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_status.size() == 0)
            begin
                report_mismatch($sformatf("unexpected status word %h", m_tdata));
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.state !== want.state)
                    report_mismatch($sformatf("fire_state %0d, want %0d",
                                              got.state, want.state));
                if (got.supp !== want.supp)
                    report_mismatch($sformatf("suppression_on %b, want %b",
                                              got.supp, want.supp));
                if (got.seen !== want.seen)
                    report_mismatch($sformatf("command_seen %b, want %b",
                                              got.seen, want.seen));
                if (got.trig !== want.trig)
                    report_mismatch($sformatf("trigger_suppression %b, want %b",
                                              got.trig, want.trig));
                if (got.cleared !== want.cleared)
                    report_mismatch($sformatf("suppression_cleared %b, want %b",
                                              got.cleared, want.cleared));
                if (got.events !== want.events)
                    report_mismatch($sformatf("event_total %0d, want %0d",
                                              got.events, want.events));
            end
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_word(logic op, logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_status.push_back(step_detector(op, ch));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_word(OP_BYTE, txt[i]);
    endtask

    task automatic send_tick_burst(int n);
        repeat (n)
            send_word(OP_TICK, 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic logic [63:0] random_text();
        logic [63:0] t;
        int k;
        for (k = 0; k < CMD_MAX; k++)
            t[8 * k +: 8] = 8'($urandom_range(8'h21, 8'h7E));
        return t;
    endfunction

    // command with random case and padding, now and then garbled or cut by a NUL
    task automatic send_command_line();
        logic [7:0] c;
        int n;
        int k;
        n = (cmd_len > CMD_MAX) ? CMD_MAX : cmd_len;
        repeat ($urandom_range(0, 3))
            send_word(OP_BYTE, blank_byte());
        for (k = 0; k < n; k++)
        begin
            c = cmd_text[8 * k +: 8];
            if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1))
                c = c ^ 8'h20;
            if ($urandom_range(19) == 0)
                c = 8'($urandom_range(8'h21, 8'h7E));
            send_word(OP_BYTE, c);
        end
        repeat ($urandom_range(0, 3))
            send_word(OP_BYTE, blank_byte());
        if ($urandom_range(6) == 0)
        begin
            send_word(OP_BYTE, 8'h00);
            repeat ($urandom_range(0, 4))
                send_word(OP_BYTE, plain_byte());
        end
        send_word(OP_BYTE, $urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic send_noise(int n);
        repeat (n)
            send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic send_long_line();
        repeat ($urandom_range(55, 70))
            send_word(OP_BYTE, plain_byte());
        send_word(OP_BYTE, CH_CR);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        if (pending_status.size() != 0)
        begin
            report_mismatch($sformatf("%0d status words missing",
                                      pending_status.size()));
            pending_status.delete();
        end
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_CMD_TEXT:  cmd_text   = val;
            REG_CMD_LEN:   cmd_len    = val[3:0];
            REG_THRESHOLD: threshold  = val[7:0];
            REG_TIMEOUT:   timeout_ms = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_command_match();
        send_text("fire");
        send_word(OP_BYTE, CH_CR);
        wait_idle();
        write_reg(REG_CMD_TEXT, 64'h6552_6946);
        write_reg(REG_CMD_LEN, 64'd4);
        write_reg(REG_THRESHOLD, 64'd2);
        write_reg(REG_TIMEOUT, 64'd4);
        send_text(" fIRE\t");
        send_word(OP_BYTE, CH_LF);
        send_word(OP_BYTE, CH_CR);
        send_text("fire");
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, CH_CR);
        send_tick_burst(5);
    endtask

    task automatic test_line_overflow();
        wait_idle();
        repeat (LINE_DEPTH - 1)
            send_word(OP_BYTE, plain_byte());
        send_word(OP_BYTE, "q");
        send_text("FIRE");
        send_word(OP_BYTE, CH_LF);
        repeat (LINE_DEPTH - 5)
            send_word(OP_BYTE, 8'h20);
        send_text("fire");
        send_word(OP_BYTE, CH_CR);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_CMD_TEXT, random_text());
        write_reg(REG_CMD_LEN, 64'd8);
        write_reg(REG_THRESHOLD, 64'd1);
        write_reg(REG_TIMEOUT, 64'd1);
        send_command_line();
        send_tick_burst(3);
        wait_idle();
        write_reg(REG_THRESHOLD, 64'd0);
        send_command_line();
        send_tick_burst(3);
        wait_idle();
        write_reg(REG_CMD_LEN, 64'd15);
        send_command_line();
        send_command_line();
        send_tick_burst(2);
        wait_idle();
        write_reg(REG_CMD_LEN, 64'd0);
        send_text(" \t");
        send_word(OP_BYTE, CH_CR);
        send_word(OP_BYTE, 8'h00);
        send_text("zz");
        send_word(OP_BYTE, CH_LF);
        send_text("a");
        send_word(OP_BYTE, CH_CR);
        wait_idle();
        write_reg(REG_CMD_TEXT, 64'h78);
        write_reg(REG_CMD_LEN, 64'd1);
        write_reg(REG_THRESHOLD, 64'd255);
        write_reg(REG_TIMEOUT, 64'd65534);
        repeat (260)
        begin
            send_word(OP_BYTE, $urandom_range(1) ? 8'h78 : 8'h58);
            send_word(OP_BYTE, CH_LF);
        end
        send_tick_burst(5);
    endtask

    task automatic test_idle_saturation();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_TIMEOUT, 64'hFFFF);
        send_text("x");
        send_word(OP_BYTE, CH_CR);
        send_tick_burst(60);
        wait_idle();
        write_reg(REG_TIMEOUT, 64'd65534);
        send_tick_burst(2);
    endtask

    task automatic test_output_stall();
        wait_idle();
        write_reg(REG_CMD_TEXT, random_text());
        write_reg(REG_CMD_LEN, 64'($urandom_range(1, CMD_MAX)));
        write_reg(REG_THRESHOLD, 64'd3);
        write_reg(REG_TIMEOUT, 64'd3000);
        @(posedge clk);
        hold_left = 400;
        @(negedge clk);
        repeat (20)
            send_command_line();
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int words);
        int stop_at;
        int pick;
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(REG_CMD_TEXT, random_text());
        write_reg(REG_CMD_LEN, 64'($urandom_range(1, CMD_MAX)));
        write_reg(REG_THRESHOLD, 64'($urandom_range(1, 5)));
        write_reg(REG_TIMEOUT, 64'($urandom_range(3, 40)));
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_command_line();
            else if (pick < 75)
                send_tick_burst($urandom_range(1, timeout_ms + 6));
            else if (pick < 90)
                send_noise($urandom_range(1, 8));
            else
                send_long_line();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        line_len     = '0;
        det_state    = FIRE_NONE;
        match_cnt    = '0;
        idle_ms      = '0;
        suppress_on  = 1'b0;
        events_begun = '0;
        cmd_text     = '0;
        cmd_len      = 4'd4;
        threshold    = 8'd3;
        timeout_ms   = 16'd3000;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 83;

        test_command_match();
        test_line_overflow();
        test_register_extremes();
        test_idle_saturation();
        test_output_stall();
        test_random_traffic(20, 83, 150);
        test_random_traffic(83, 20, 150);
        test_random_traffic(0, 0, 150);

        wait_idle();
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
